// File: sv/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg
// shared constants and types of the bilinear image rotator
// ----------------------------------------------------------------------------
package bir_pkg;

    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int Channels  = 4;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int BankDepth = (MaxWidth / 2) * (MaxHeight / 2);
    localparam int BankAw    = $clog2(BankDepth);

    localparam logic [2:0] RegSrcW  = 3'd0;
    localparam logic [2:0] RegSrcH  = 3'd1;
    localparam logic [2:0] RegTgtW  = 3'd2;
    localparam logic [2:0] RegTgtH  = 3'd3;
    localparam logic [2:0] RegCos   = 3'd4;
    localparam logic [2:0] RegSin   = 3'd5;
    localparam logic [2:0] RegChans = 3'd6;

    localparam logic ModeLoad    = 1'b0;
    localparam logic ModeCompute = 1'b1;

    typedef struct packed {
        logic [ColW-1:0] x1;
        logic [ColW-1:0] x2;
        logic [RowW-1:0] y1;
        logic [RowW-1:0] y2;
    } t_nbr;

endpackage

// File: sv/bir_store.sv
// ----------------------------------------------------------------------------
// bir_store
// source pixel store split into four banks by column and row parity
// ----------------------------------------------------------------------------
module bir_store (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [bir_pkg::ColW-1:0] i_wcol,
    input  logic [bir_pkg::RowW-1:0] i_wrow,
    input  logic [31:0]        i_wdata,
    input  logic               i_re,
    input  bir_pkg::t_nbr      i_nbr,
    output logic [31:0]        o_p1,
    output logic [31:0]        o_p2,
    output logic [31:0]        o_p3,
    output logic [31:0]        o_p4
);
    localparam int HC = bir_pkg::ColW - 1;
    localparam int HR = bir_pkg::RowW - 1;

    logic [31:0] r_bank0 [bir_pkg::BankDepth];
    logic [31:0] r_bank1 [bir_pkg::BankDepth];
    logic [31:0] r_bank2 [bir_pkg::BankDepth];
    logic [31:0] r_bank3 [bir_pkg::BankDepth];
    logic [31:0] r_q [4];
    logic [1:0]  r_sel_x, r_sel_y;
    logic [bir_pkg::BankAw-1:0] waddr;
    logic [1:0] wb;
    logic [HC-1:0] ce, co;
    logic [HR-1:0] re_, ro;
    logic xo1, yo1;

    assign waddr = {i_wrow[bir_pkg::RowW-1:1], i_wcol[bir_pkg::ColW-1:1]};
    assign wb    = {i_wrow[0], i_wcol[0]};
    // even and odd column of the pair
    assign xo1 = i_nbr.x1[0];
    assign yo1 = i_nbr.y1[0];
    assign ce  = xo1 ? i_nbr.x2[bir_pkg::ColW-1:1] : i_nbr.x1[bir_pkg::ColW-1:1];
    assign co  = xo1 ? i_nbr.x1[bir_pkg::ColW-1:1] : i_nbr.x2[bir_pkg::ColW-1:1];
    assign re_ = yo1 ? i_nbr.y2[bir_pkg::RowW-1:1] : i_nbr.y1[bir_pkg::RowW-1:1];
    assign ro  = yo1 ? i_nbr.y1[bir_pkg::RowW-1:1] : i_nbr.y2[bir_pkg::RowW-1:1];

    always_ff @(posedge i_clk) begin
        if (i_we && wb == 2'd0) r_bank0[waddr] <= i_wdata;
        if (i_we && wb == 2'd1) r_bank1[waddr] <= i_wdata;
        if (i_we && wb == 2'd2) r_bank2[waddr] <= i_wdata;
        if (i_we && wb == 2'd3) r_bank3[waddr] <= i_wdata;
        if (i_re) begin
            r_q[0]  <= r_bank0[{re_, ce}];
            r_q[1]  <= r_bank1[{re_, co}];
            r_q[2]  <= r_bank2[{ro, ce}];
            r_q[3]  <= r_bank3[{ro, co}];
            // bank of each neighbour: bit0 column parity, bit1 row parity
            r_sel_x <= {i_nbr.x2[0], i_nbr.x1[0]};
            r_sel_y <= {i_nbr.y2[0], i_nbr.y1[0]};
        end
    end

    assign o_p1 = r_q[{r_sel_y[0], r_sel_x[0]}];
    assign o_p2 = r_q[{r_sel_y[0], r_sel_x[1]}];
    assign o_p3 = r_q[{r_sel_y[1], r_sel_x[0]}];
    assign o_p4 = r_q[{r_sel_y[1], r_sel_x[1]}];
endmodule

// File: sv/bilinear_image_rotator_unit.sv
// ----------------------------------------------------------------------------
// bilinear_image_rotator_unit
// rotates a stored image about its centre with bilinear interpolation
// ----------------------------------------------------------------------------
// One item per clock. A load transfer (tuser 0) writes a source pixel and
// returns a zero result; a compute transfer (tuser 1) returns one
// interpolated destination pixel. The path is six stages: coordinate
// products, position, neighbour clamp and store read, horizontal blend,
// vertical blend, output register. The four neighbours come from a store
// split into four banks by row and column parity, so one read per bank per
// cycle serves every pixel. A load is written at the store one stage after
// it enters and a compute reads the store two stages after it enters, so a
// compute sees exactly the loads accepted before it. A result is presented
// from the output register and can transfer at the next edge; while it
// waits at the output the whole path holds and the input is not ready.
module bilinear_image_rotator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // col, row, in_chan0..in_chan3
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_chan0..out_chan3
    output logic        m_axis_tuser,   // inside_res
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    localparam int NS = 6;

    logic [8:0] r_sw, r_sh, r_tw, r_th;
    logic signed [15:0] r_cos, r_sin;
    logic [2:0] r_nch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= 9'd256; r_sh <= 9'd256; r_tw <= 9'd256; r_th <= 9'd256;
            r_cos <= 16'sd16384; r_sin <= '0; r_nch <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bir_pkg::RegSrcW:  r_sw  <= i_cfg_data[8:0];
                bir_pkg::RegSrcH:  r_sh  <= i_cfg_data[8:0];
                bir_pkg::RegTgtW:  r_tw  <= i_cfg_data[8:0];
                bir_pkg::RegTgtH:  r_th  <= i_cfg_data[8:0];
                bir_pkg::RegCos:   r_cos <= i_cfg_data;
                bir_pkg::RegSin:   r_sin <= i_cfg_data;
                bir_pkg::RegChans: r_nch <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clamped sizes
    logic [8:0] sw, sh;
    logic [2:0] nch;
    assign sw  = (r_sw == 0) ? 9'd1 : (r_sw > 9'd256 ? 9'd256 : r_sw);
    assign sh  = (r_sh == 0) ? 9'd1 : (r_sh > 9'd256 ? 9'd256 : r_sh);
    assign nch = (r_nch == 0) ? 3'd1 : (r_nch > 3'd4 ? 3'd4 : r_nch);

    // pipeline control
    logic [NS-2:0] r_v;
    logic          adv;
    logic          r_ov;
    assign adv = !r_ov || m_axis_tready;
    assign s_axis_tready = adv;
    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NS-3:0], acc};
    end

    // stage 1: products
    logic signed [10:0] cx2, cy2;
    logic signed [27:0] r_sc, r_cc, r_ccy, r_ssx;
    logic r_m1;
    logic r_ld1;
    logic [47:0] r_d1;
    assign cx2 = $signed({2'b0, s_axis_tdata[7:0], 1'b0}) - $signed({2'b0, r_tw}) + 11'sd1;
    assign cy2 = $signed({2'b0, s_axis_tdata[15:8], 1'b0}) - $signed({2'b0, r_th}) + 11'sd1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sc  <= 28'(r_sin * cy2);
            r_cc  <= 28'(r_cos * cx2);
            r_ccy <= 28'(r_cos * cy2);
            r_ssx <= 28'(r_sin * cx2);
            r_m1  <= acc && s_axis_tuser == bir_pkg::ModeCompute;
            r_d1  <= s_axis_tdata;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ld1 <= 1'b0;
        else if (adv) r_ld1 <= acc && s_axis_tuser == bir_pkg::ModeLoad;
    end

    // stage 2: position in Q16
    logic signed [31:0] ox, oy;
    logic signed [31:0] r_ox, r_oy;
    logic r_m2;
    assign ox = 32'(($signed({{4{r_sc[27]}}, r_sc}) + $signed({{4{r_cc[27]}}, r_cc})) * 2)
              + $signed({8'b0, sw - 9'd1, 15'b0});
    assign oy = 32'(($signed({{4{r_ccy[27]}}, r_ccy}) - $signed({{4{r_ssx[27]}}, r_ssx})) * 2)
              + $signed({8'b0, sh - 9'd1, 15'b0});
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ox <= ox; r_oy <= oy; r_m2 <= r_m1;
        end
    end

    // stage 3: neighbours, weights, store read
    logic in_x, in_y;
    logic [15:0] ix, iy;
    logic [16:0] dx, dy;
    bir_pkg::t_nbr nbr;
    assign ix = r_ox[31:16] + ((r_ox[31] && r_ox[15:0] != 0) ? 16'd1 : 16'd0);
    assign iy = r_oy[31:16] + ((r_oy[31] && r_oy[15:0] != 0) ? 16'd1 : 16'd0);
    assign in_x = !ix[15] && (ix < {7'b0, sw});
    assign in_y = !iy[15] && (iy < {7'b0, sh});
    assign dx = r_ox[31] ? 17'd0 : {1'b0, r_ox[15:0]};
    assign dy = r_oy[31] ? 17'd0 : {1'b0, r_oy[15:0]};
    assign nbr.x1 = ix[7:0];
    assign nbr.y1 = iy[7:0];
    assign nbr.x2 = ({1'b0, ix[7:0]} == sw - 9'd1) ? ix[7:0] : ix[7:0] + 8'd1;
    assign nbr.y2 = ({1'b0, iy[7:0]} == sh - 9'd1) ? iy[7:0] : iy[7:0] + 8'd1;

    logic [16:0] r_dx, r_dy, r_dy4;
    logic r_in3, r_in4, r_in5;
    logic [2:0] r_n3, r_n4, r_n5;
    logic [31:0] p1, p2, p3, p4;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx <= dx; r_dy <= dy;
            r_in3 <= r_m2 && in_x && in_y;
            r_n3 <= nch;
        end
    end

    bir_store u_store (
        .i_clk  (i_clk),
        .i_we   (adv && r_ld1),
        .i_wcol (r_d1[7:0]),
        .i_wrow (r_d1[15:8]),
        .i_wdata(r_d1[47:16]),
        .i_re   (adv),
        .i_nbr  (nbr),
        .o_p1   (p1), .o_p2(p2), .o_p3(p3), .o_p4(p4)
    );

    // stage 4: horizontal blend
    logic [24:0] r_top [4];
    logic [24:0] r_bot [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_top[k] <= 25'((17'd65536 - r_dx) * p1[8*k +: 8] + r_dx * p2[8*k +: 8]);
                r_bot[k] <= 25'((17'd65536 - r_dx) * p3[8*k +: 8] + r_dx * p4[8*k +: 8]);
            end
            r_dy4 <= r_dy; r_in4 <= r_in3; r_n4 <= r_n3;
        end
    end

    // stage 5: vertical blend
    logic [7:0] r_v5 [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_v5[k] <= 8'((42'((17'd65536 - r_dy4) * r_top[k])
                             + 42'(r_dy4 * r_bot[k])) >> 32);
            end
            r_in5 <= r_in4; r_n5 <= r_n4;
        end
    end

    // stage 6: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_v[NS-2];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            m_axis_tuser <= r_in5;
            for (int k = 0; k < 4; k++)
                m_axis_tdata[8*k +: 8] <= (r_in5 && k < r_n5) ? r_v5[k] : 8'd0;
        end
    end
    assign m_axis_tvalid = r_ov;
endmodule

// File: sv/bir_checker.sv
// ----------------------------------------------------------------------------
// bir_checker
// port level checks of the rotator
// ----------------------------------------------------------------------------
module bir_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("ready while stalled");
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0) else $error("nonzero outside");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid) else $error("valid after reset");
endmodule

bind bilinear_image_rotator_unit bir_checker u_bir_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bilinear image rotator
// ----------------------------------------------------------------------------
// Loads source pixels and asks for rotated destination pixels over several
// register settings, from size and coefficient extremes to random angles on
// small images. Each compute transfer is predicted with a local model of
// the back-mapping and bilinear blend, or typed in the directed table. The
// result stream is compared in order. Both stream sides idle at random,
// and once the output is held off long enough to back up the input.
module tb;

    localparam int LIMIT = 400000;

    typedef struct packed {
        logic        in_src;
        logic [31:0] px;
    } t_pix_res;

    typedef struct packed {
        logic        mode;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [31:0] px;
        logic        typed;
        logic        exp_in_src;
        logic [31:0] exp_px;
    } t_dir_row;

    localparam t_dir_row DIR_TAB [18] = '{
        '{bir_pkg::ModeLoad,    8'd0,   8'd0,   32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd1,   8'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd0,   8'd1,   32'h1234_5678, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd1,   8'd1,   32'hC3C3_C3A5, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd2,   8'd0,   32'h3C3C_3C3C, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd2,   8'd1,   32'h9696_9696, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd1,   8'd2,   32'h6969_6969, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd2,   8'd2,   32'h0101_0101, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd254, 8'd254, 32'h5555_5580, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd255, 8'd254, 32'hAAAA_AA7F, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd254, 8'd255, 32'h0F0F_0F01, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeLoad,    8'd255, 8'd255, 32'hFFFF_FFFE, 1'b1, 1'b0, 32'h0},
        '{bir_pkg::ModeCompute, 8'd0,   8'd0,   32'h0,         1'b1, 1'b1, 32'h0000_00FF},
        '{bir_pkg::ModeCompute, 8'd1,   8'd1,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_00A5},
        '{bir_pkg::ModeCompute, 8'd255, 8'd255, 32'h0,         1'b1, 1'b1, 32'h0000_00FE},
        '{bir_pkg::ModeCompute, 8'd254, 8'd254, 32'h0,         1'b1, 1'b1, 32'h0000_0080},
        '{bir_pkg::ModeCompute, 8'd255, 8'd254, 32'h0,         1'b1, 1'b1, 32'h0000_007F},
        '{bir_pkg::ModeCompute, 8'd1,   8'd0,   32'h0,         1'b1, 1'b1, 32'h0000_0000}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // col, row, in_chan0..in_chan3
    logic        s_axis_tuser = 1'b0; // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // out_chan0..out_chan3
    logic        m_axis_tuser;        // inside_res
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    bilinear_image_rotator_unit i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // local copy of the registers and the source image
    logic [8:0]         src_w, src_h, tgt_w, tgt_h;
    logic signed [15:0] cos_q, sin_q;
    logic [2:0]         n_chan;
    logic [31:0]        pix_mem [0:65535];
    bit                 pix_set [0:65535];

    t_pix_res pending_pix [$];
    int errors = 0;
    int n_acc = 0;
    int n_loads = 0;
    int n_computes = 0;
    int n_inside = 0;
    int n_phases = 0;
    int cycles = 0;
    bit quiet;
    bit hold_done = 1'b0;
    int hold_left = 0;

    assign quiet = (n_acc >= 400) && (n_acc < 520);

    function automatic longint clamp_size(logic [8:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return longint'(v);
    endfunction

    function automatic t_pix_res rotate_pixel(logic [7:0] col, logic [7:0] row);
        t_pix_res r;
        longint sw, sh, nch, cx2, cy2, ox, oy, ox1, oy1, ox2, oy2, dx, dy;
        longint top, bot, v;
        logic [31:0] q1, q2, q3, q4;
        r = '0;
        sw  = clamp_size(src_w);
        sh  = clamp_size(src_h);
        nch = (n_chan == 0) ? 1 : ((n_chan > bir_pkg::Channels) ? bir_pkg::Channels : n_chan);
        cx2 = 2 * longint'(col) - (longint'(tgt_w) - 1);
        cy2 = 2 * longint'(row) - (longint'(tgt_h) - 1);
        ox = 2 * (longint'(sin_q) * cy2 + longint'(cos_q) * cx2) + (sw - 1) * 32768;
        oy = 2 * (longint'(cos_q) * cy2 - longint'(sin_q) * cx2) + (sh - 1) * 32768;
        ox1 = ox / 65536;
        oy1 = oy / 65536;
        if (ox1 < 0 || oy1 < 0 || ox1 >= sw || oy1 >= sh) return r;
        ox2 = (ox1 == sw - 1) ? ox1 : ox1 + 1;
        oy2 = (oy1 == sh - 1) ? oy1 : oy1 + 1;
        dx = ox - ox1 * 65536;
        dy = oy - oy1 * 65536;
        if (dx < 0) dx = 0;
        if (dy < 0) dy = 0;
        q1 = pix_mem[oy1 * 256 + ox1];
        q2 = pix_mem[oy1 * 256 + ox2];
        q3 = pix_mem[oy2 * 256 + ox1];
        q4 = pix_mem[oy2 * 256 + ox2];
        r.in_src = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (k < nch) begin
                top = (65536 - dx) * q1[8*k +: 8] + dx * q2[8*k +: 8];
                bot = (65536 - dx) * q3[8*k +: 8] + dx * q4[8*k +: 8];
                v = ((65536 - dy) * top + dy * bot) >>> 32;
                r.px[8*k +: 8] = v[7:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // one input transfer; the expectation is typed or predicted
    task automatic send_pixel(logic mode, logic [7:0] col, logic [7:0] row,
                              logic [31:0] px, bit typed = 0, t_pix_res typed_res = '0);
        t_pix_res r;
        while (!quiet && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {px, row, col};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_acc++;
        if (mode == bir_pkg::ModeLoad) begin
            pix_mem[{row, col}] = px;
            pix_set[{row, col}] = 1'b1;
            r = '0;
            n_loads++;
        end else begin
            r = rotate_pixel(col, row);
            n_computes++;
            if (r.in_src) n_inside++;
        end
        pending_pix.push_back(typed ? typed_res : r);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_regs(int sw, int sh, int tw, int th, int cs, int sn, int ch);
        logic [15:0] vals [7];
        vals = '{16'(sw), 16'(sh), 16'(tw), 16'(th), 16'(cs), 16'(sn), 16'(ch)};
        drain();
        for (int i = 0; i < 7; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(i);
            i_cfg_data <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        src_w  = vals[bir_pkg::RegSrcW][8:0];
        src_h  = vals[bir_pkg::RegSrcH][8:0];
        tgt_w  = vals[bir_pkg::RegTgtW][8:0];
        tgt_h  = vals[bir_pkg::RegTgtH][8:0];
        cos_q  = vals[bir_pkg::RegCos];
        sin_q  = vals[bir_pkg::RegSin];
        n_chan = vals[bir_pkg::RegChans][2:0];
        n_phases++;
    endtask

    // writes every source pixel a compute could reach, then mixed traffic
    task automatic run_phase(int n_items);
        longint sw, sh, tw, th;
        logic [7:0] c, r;
        sw = clamp_size(src_w);
        sh = clamp_size(src_h);
        tw = clamp_size(tgt_w);
        th = clamp_size(tgt_h);
        for (int y = 0; y < sh; y++)
            for (int x = 0; x < sw; x++)
                if (!pix_set[y * 256 + x])
                    send_pixel(bir_pkg::ModeLoad, 8'(x), 8'(y), $urandom);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 25) begin
                if ($urandom_range(7) == 0) begin
                    c = 8'($urandom_range(255));
                    r = 8'($urandom_range(255));
                end else begin
                    c = 8'($urandom_range(sw - 1));
                    r = 8'($urandom_range(sh - 1));
                end
                send_pixel(bir_pkg::ModeLoad, c, r, $urandom);
            end else begin
                if ($urandom_range(7) == 0) begin
                    c = 8'($urandom_range(255));
                    r = 8'($urandom_range(255));
                end else begin
                    c = 8'($urandom_range(tw - 1));
                    r = 8'($urandom_range(th - 1));
                end
                send_pixel(bir_pkg::ModeCompute, c, r, $urandom);
            end
        end
    endtask

    function automatic int rand_coef();
        case ($urandom_range(9))
            0: return -16384;
            1: return 16384;
            2: return 0;
            default: return int'($urandom_range(32768)) - 16384;
        endcase
    endfunction

    // output side: random stalls and one long hold-off
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
        if (!hold_done && n_acc >= 200) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        t_pix_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pix.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = pending_pix.pop_front();
                if (m_axis_tuser !== e.in_src)
                    report_mismatch($sformatf("inside %0b, want %0b", m_axis_tuser, e.in_src));
                for (int k = 0; k < 4; k++)
                    if (m_axis_tdata[8*k +: 8] !== e.px[8*k +: 8])
                        report_mismatch($sformatf("chan%0d %02h, want %02h", k,
                                        m_axis_tdata[8*k +: 8], e.px[8*k +: 8]));
            end
        end
    end

    initial begin
        t_pix_res t;
        foreach (pix_set[i]) pix_set[i] = 1'b0;
        src_w = 256; src_h = 256; tgt_w = 256; tgt_h = 256;
        cos_q = 16384; sin_q = 0; n_chan = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity mapping after reset
        foreach (DIR_TAB[i]) begin
            t.in_src = DIR_TAB[i].exp_in_src;
            t.px     = DIR_TAB[i].exp_px;
            send_pixel(DIR_TAB[i].mode, DIR_TAB[i].col, DIR_TAB[i].row, DIR_TAB[i].px,
                       DIR_TAB[i].typed, t);
        end

        write_regs(1, 1, 1, 1, 16384, 0, 4);
        run_phase(20);
        write_regs(0, 511, 300, 0, -16384, 16384, 0);
        run_phase(30);
        write_regs(511, 1, 256, 9, 11585, 11585, 7);
        run_phase(30);
        write_regs(8, 8, 12, 12, 32767, -32768, 4);
        run_phase(25);
        write_regs(256, 1, 0, 511, -16384, -16384, 2);
        run_phase(25);
        for (int p = 0; p < 6; p++) begin
            write_regs($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(1, 24),
                       $urandom_range(1, 24), rand_coef(), rand_coef(),
                       $urandom_range(1, 4));
            run_phase(15);
        end

        drain();
        $display("%0d loads and %0d computes (%0d inside) over %0d register settings",
                 n_loads, n_computes, n_inside, n_phases);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
